// File: rtl/wvnb_pkg.sv
// ----------------------------------------------------------------------------
// wvnb_pkg
// Types, constants and codes shared by the neighbour buffer and its checker.
// ----------------------------------------------------------------------------
package wvnb_pkg;

   localparam int STORE_DEPTH = 32;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_NEXT   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_NO_CUR = 2'd2;

   localparam logic [1:0] ROLE_BEFORE  = 2'd0;
   localparam logic [1:0] ROLE_CURRENT = 2'd1;
   localparam logic [1:0] ROLE_AFTER   = 2'd2;
   localparam logic [1:0] ROLE_STATUS  = 2'd3;

   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [1:0] CSR_NONOVERLAP  = 2'd1;

   typedef struct packed {
      logic [15:0] contig;
      logic [31:0] pos;
      logic [15:0] len;
   } rec_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] contig_id;
      logic [31:0] position;
      logic [15:0] ref_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  role;
      logic [15:0] out_contig;
      logic [31:0] out_position;
      logic [15:0] out_ref_length;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CUR_RD,
      S_CUR_CK,
      S_DROP_RD,
      S_DROP_CK,
      S_ADM_RD,
      S_ADM_CK,
      S_EMIT_RD,
      S_EMIT_CK,
      S_EMIT_CUR,
      S_FLUSH
   } state_type;

endpackage

// File: rtl/windowed_variant_neighbour_buffer.sv
// ----------------------------------------------------------------------------
// windowed_variant_neighbour_buffer
// Ring of sorted variant records; emits windowed neighbours on each advance.
// ----------------------------------------------------------------------------
// Push, clear and an advance with nothing pending give one status word in
// the cycle after acceptance. Any other advance fetches the current record,
// drops earlier records that fell out of the window, tests pending records
// for admission, walks the records for emission and flushes the final word;
// a stalled output holds the walk. One item at a time: a new item is taken
// only in idle with no word waiting. Reset (synchronous) empties the ring.
module windowed_variant_neighbour_buffer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  wvnb_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wvnb_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import wvnb_pkg::*;

   // record store: one write port, one registered read port; writes happen
   // only when an item is accepted in idle, so a walk never meets a write
   rec_type          mem [STORE_DEPTH];
   rec_type          rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   logic             wr_en;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]   oldest_ff, oldest_in, cur_ff, cur_in, wr_ff, wr_in;
   logic [CNT_W-1:0]   stored_ff, stored_in, before_ff, before_in;
   logic [CNT_W-1:0]   after_ff, after_in, pend_ff, pend_in, walk_ff, walk_in;
   logic               has_cur_ff, has_cur_in;
   logic               phase_ff, phase_in;   // 0 earlier records, 1 later records
   rec_type            cur_rec_ff, cur_rec_in;
   logic signed [33:0] used_ff, used_in;     // end of the last taken record
   logic [31:0]        win_ff;
   logic               nonov_ff;
   logic               out_v_ff, out_v_in;
   rsp_type            out_ff, out_in;
   // one word held back so that the final word of an advance can carry last
   logic               hold_v_ff, hold_v_in;
   rsp_type            hold_ff, hold_in;

   logic               req_take, rsp_take, out_free, can_take;
   logic [CNT_W-1:0]   before_next, pend_next;
   logic [32:0]        gap_back, gap_fwd, rd_end, cur_end;
   logic               keep_old, admit, pick;
   logic signed [33:0] rd_pos_s, rd_last_s, cur_last_s;

   assign csr_ready = 1'b1;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign req_stall = (state_ff != S_IDLE) || out_v_ff;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = out_v_ff && !rsp_stall;
   assign out_free = !out_v_ff || rsp_take;
   // a new candidate may enter the hold slot when the slot is empty or can drain
   assign can_take = !hold_v_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         nonov_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE: win_ff   <= csr_wdata;
            CSR_NONOVERLAP:  nonov_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // memory write and read
   assign wr_en = req_take && (req_data.func == FUNC_PUSH) &&
                  (stored_ff < CNT_W'(STORE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_ff] <= '{contig: req_data.contig_id, pos: req_data.position,
                         len: req_data.ref_length};
      if (rd_en)
         rd_ff <= mem[rd_addr];
   end

   function automatic logic [IDX_W-1:0] radd(input logic [IDX_W-1:0] b,
                                             input logic [CNT_W-1:0] k);
      logic [CNT_W:0] s;
      s = {{(CNT_W + 1 - IDX_W){1'b0}}, b} + {1'b0, k};
      radd = IDX_W'(s % STORE_DEPTH);
   endfunction

   // address for the walks
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         S_CUR_RD: begin
            rd_en   = 1'b1;
            rd_addr = cur_ff;
         end
         S_DROP_RD: begin
            rd_en   = 1'b1;
            rd_addr = oldest_ff;
         end
         S_ADM_RD: begin
            rd_en   = 1'b1;
            rd_addr = radd(cur_ff, after_ff + CNT_W'(1));
         end
         S_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = phase_ff ? radd(cur_ff, walk_ff + CNT_W'(1))
                               : radd(oldest_ff, walk_ff);
         end
         default: ;
      endcase
   end

   // distances: a neighbour on the wrong side borrows and counts as too far
   assign gap_back = {1'b0, cur_rec_ff.pos} - {1'b0, rd_ff.pos};
   assign gap_fwd  = {1'b0, rd_ff.pos} - {1'b0, cur_rec_ff.pos};
   assign keep_old = (rd_ff.contig == cur_rec_ff.contig) && !gap_back[32] &&
                     (gap_back[31:0] <= win_ff);
   assign admit    = (rd_ff.contig == cur_rec_ff.contig) && !gap_fwd[32] &&
                     (gap_fwd[31:0] <= win_ff);

   assign rd_end     = {1'b0, rd_ff.pos} + {17'd0, rd_ff.len};
   assign cur_end    = {1'b0, cur_rec_ff.pos} + {17'd0, cur_rec_ff.len};
   assign rd_pos_s   = signed'({2'b00, rd_ff.pos});
   assign rd_last_s  = signed'({1'b0, rd_end}) - 34'sd1;
   assign cur_last_s = signed'({1'b0, cur_end}) - 34'sd1;
   // non-overlapping pick: strictly past the last taken end; earlier records
   // must also end before the current one (position zero is never taken first)
   assign pick = !nonov_ff ||
                 ((rd_pos_s > used_ff) && (phase_ff || rd_end <= {1'b0, cur_rec_ff.pos}));

   // the old current joins the earlier records on an advance
   assign before_next = has_cur_ff ? before_ff + CNT_W'(1) : before_ff;
   assign pend_next   = stored_ff - before_next;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take && req_data.func == FUNC_NEXT && pend_next != '0)
               state_in = S_CUR_RD;
         end
         S_CUR_RD:  state_in = S_CUR_CK;
         S_CUR_CK:  state_in = (before_ff != '0) ? S_DROP_RD : S_ADM_RD;
         S_DROP_RD: state_in = S_DROP_CK;
         S_DROP_CK: begin
            if (keep_old || before_ff == CNT_W'(1)) state_in = S_ADM_RD;
            else state_in = S_DROP_RD;
         end
         S_ADM_RD:  state_in = (after_ff + CNT_W'(1) < pend_ff) ? S_ADM_CK : S_EMIT_RD;
         S_ADM_CK:  state_in = admit ? S_ADM_RD : S_EMIT_RD;
         S_EMIT_RD: begin
            if (!phase_ff && walk_ff < before_ff) state_in = S_EMIT_CK;
            else if (!phase_ff) state_in = S_EMIT_CUR;
            else if (walk_ff < after_ff) state_in = S_EMIT_CK;
            else state_in = S_FLUSH;
         end
         S_EMIT_CK: begin
            if (!pick || can_take) state_in = S_EMIT_RD;
         end
         S_EMIT_CUR: begin
            if (can_take) state_in = S_EMIT_RD;
         end
         S_FLUSH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and emission
   always_comb begin
      oldest_in  = oldest_ff;
      cur_in     = cur_ff;
      wr_in      = wr_ff;
      stored_in  = stored_ff;
      before_in  = before_ff;
      after_in   = after_ff;
      pend_in    = pend_ff;
      walk_in    = walk_ff;
      has_cur_in = has_cur_ff;
      phase_in   = phase_ff;
      cur_rec_in = cur_rec_ff;
      used_in    = used_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff && !rsp_take;
      hold_in    = hold_ff;
      hold_v_in  = hold_v_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               out_in = '{status: ST_OK, role: ROLE_STATUS, out_contig: 16'd0,
                          out_position: 32'd0, out_ref_length: 16'd0, last: 1'b1};
               unique case (req_data.func)
                  FUNC_PUSH: begin
                     out_v_in = 1'b1;
                     if (wr_en) begin
                        wr_in     = radd(wr_ff, CNT_W'(1));
                        stored_in = stored_ff + CNT_W'(1);
                     end else begin
                        out_in.status = ST_FULL;
                     end
                  end
                  FUNC_NEXT: begin
                     before_in = before_next;
                     if (has_cur_ff) cur_in = radd(cur_ff, CNT_W'(1));
                     pend_in  = pend_next;
                     walk_in  = '0;
                     phase_in = 1'b0;
                     used_in  = '0;
                     if (pend_next == '0) begin
                        // nothing pending: no current remains
                        after_in      = '0;
                        has_cur_in    = 1'b0;
                        out_in.status = ST_NO_CUR;
                        out_v_in      = 1'b1;
                     end else begin
                        has_cur_in = 1'b1;
                        if (after_ff != '0) after_in = after_ff - CNT_W'(1);
                     end
                  end
                  FUNC_CLEAR: begin
                     oldest_in  = '0;
                     cur_in     = '0;
                     wr_in      = '0;
                     stored_in  = '0;
                     before_in  = '0;
                     after_in   = '0;
                     has_cur_in = 1'b0;
                     out_v_in   = 1'b1;
                  end
                  default: ;   // unused code: drop silently
               endcase
            end
         end
         S_CUR_CK: cur_rec_in = rd_ff;
         S_DROP_CK: begin
            if (!keep_old) begin
               oldest_in = radd(oldest_ff, CNT_W'(1));
               before_in = before_ff - CNT_W'(1);
               stored_in = stored_ff - CNT_W'(1);
            end
         end
         S_ADM_CK: begin
            if (admit) after_in = after_ff + CNT_W'(1);
         end
         S_EMIT_CK: begin
            if (pick && can_take) begin
               // advance the held word to the output, hold the new one
               if (hold_v_ff) begin
                  out_in   = hold_ff;
                  out_v_in = 1'b1;
               end
               hold_in   = '{status: ST_OK, role: phase_ff ? ROLE_AFTER : ROLE_BEFORE,
                             out_contig: rd_ff.contig, out_position: rd_ff.pos,
                             out_ref_length: rd_ff.len, last: 1'b0};
               hold_v_in = 1'b1;
               used_in   = rd_last_s;
            end
            if (!pick || can_take) walk_in = walk_ff + CNT_W'(1);
         end
         S_EMIT_CUR: begin
            if (can_take) begin
               if (hold_v_ff) begin
                  out_in   = hold_ff;
                  out_v_in = 1'b1;
               end
               hold_in   = '{status: ST_OK, role: ROLE_CURRENT,
                             out_contig: cur_rec_ff.contig, out_position: cur_rec_ff.pos,
                             out_ref_length: cur_rec_ff.len, last: 1'b0};
               hold_v_in = 1'b1;
               used_in   = cur_last_s;
               phase_in  = 1'b1;
               walk_in   = '0;
            end
         end
         S_FLUSH: begin
            // the held word is the final one of the advance
            if (out_free) begin
               out_in      = hold_ff;
               out_in.last = 1'b1;
               out_v_in    = 1'b1;
               hold_v_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         oldest_ff  <= '0;
         cur_ff     <= '0;
         wr_ff      <= '0;
         stored_ff  <= '0;
         before_ff  <= '0;
         after_ff   <= '0;
         pend_ff    <= '0;
         walk_ff    <= '0;
         has_cur_ff <= 1'b0;
         phase_ff   <= 1'b0;
         used_ff    <= '0;
         out_v_ff   <= 1'b0;
         out_ff     <= '0;
         hold_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         oldest_ff  <= oldest_in;
         cur_ff     <= cur_in;
         wr_ff      <= wr_in;
         stored_ff  <= stored_in;
         before_ff  <= before_in;
         after_ff   <= after_in;
         pend_ff    <= pend_in;
         walk_ff    <= walk_in;
         has_cur_ff <= has_cur_in;
         phase_ff   <= phase_in;
         used_ff    <= used_in;
         out_v_ff   <= out_v_in;
         out_ff     <= out_in;
         hold_v_ff  <= hold_v_in;
      end
   end

   // data held alongside valid flags needs no reset
   always_ff @(posedge clock) begin
      cur_rec_ff <= cur_rec_in;
      hold_ff    <= hold_in;
   end

endmodule

// File: rtl/wvnb_checker.sv
// ----------------------------------------------------------------------------
// wvnb_checker
// Port-level checks for the neighbour buffer.
// ----------------------------------------------------------------------------
module wvnb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input wvnb_pkg::rsp_type rsp_data
);
   import wvnb_pkg::*;

   // hold a stalled result word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // status-only words always close their item
   a_stat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.role == ROLE_STATUS |-> rsp_data.last)
      else $error("status word without last");

   // record words always carry status ok
   a_rec_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.role != ROLE_STATUS |-> rsp_data.status == ST_OK)
      else $error("record word with bad status");

   // no new item while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !rsp_valid)
      else $error("input taken while result pending");

endmodule

bind windowed_variant_neighbour_buffer wvnb_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

// File: tb/tb_windowed_variant_neighbour_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_variant_neighbour_buffer
// Drives pushes, advances and clears into the neighbour buffer under random
// idling on both channels, predicts every emitted word and checks them.
// ----------------------------------------------------------------------------
module tb_windowed_variant_neighbour_buffer;
   import wvnb_pkg::*;

   // Window predictor and store of expected words
   class window_scoreboard;
      rec_type     ring [STORE_DEPTH];
      int unsigned oldest, cur_idx, wr_idx, stored, kept_before, admitted;
      bit          has_cur;
      logic [31:0] window;
      bit          nonoverlap;
      rsp_type     pending_words [$];
      int          errors;

      function void reset_state();
         oldest = 0; cur_idx = 0; wr_idx = 0; stored = 0;
         kept_before = 0; admitted = 0; has_cur = 0;
      endfunction

      function void queue_word(logic [1:0] st, logic [1:0] role, rec_type r, bit lst);
         rsp_type w;
         w.status = st; w.role = role;
         w.out_contig = r.contig; w.out_position = r.pos; w.out_ref_length = r.len;
         w.last = lst;
         pending_words.insert(pending_words.size(), w);
      endfunction

      function void queue_status(logic [1:0] st);
         queue_word(st, ROLE_STATUS, '0, 1'b1);
      endfunction

      function void queue_window();
         rec_type cur, r;
         longint  used, p, cpos;
         cur  = ring[cur_idx];
         cpos = longint'(cur.pos);
         used = 0;
         for (int i = 0; i < kept_before; i++) begin
            r = ring[(oldest + i) % STORE_DEPTH];
            p = longint'(r.pos);
            if (!nonoverlap) queue_word(ST_OK, ROLE_BEFORE, r, 1'b0);
            else if (p > used && p + longint'(r.len) <= cpos) begin
               queue_word(ST_OK, ROLE_BEFORE, r, 1'b0);
               used = p + longint'(r.len) - 1;
            end
         end
         queue_word(ST_OK, ROLE_CURRENT, cur, 1'b0);
         used = cpos + longint'(cur.len) - 1;
         for (int i = 0; i < admitted; i++) begin
            r = ring[(cur_idx + i + 1) % STORE_DEPTH];
            p = longint'(r.pos);
            if (!nonoverlap) queue_word(ST_OK, ROLE_AFTER, r, 1'b0);
            else if (p > used) begin
               queue_word(ST_OK, ROLE_AFTER, r, 1'b0);
               used = p + longint'(r.len) - 1;
            end
         end
         pending_words[$].last = 1'b1;
      endfunction

      function void advance();
         int unsigned waiting;
         rec_type     cur, o;
         logic [63:0] span;
         if (has_cur) begin
            kept_before++;
            cur_idx = (cur_idx + 1) % STORE_DEPTH;
            has_cur = 0;
         end
         waiting = stored - kept_before;
         if (waiting == 0) begin
            admitted = 0;
            queue_status(ST_NO_CUR);
            return;
         end
         has_cur = 1;
         if (admitted > 0) admitted--;
         cur = ring[cur_idx];
         // drop earlier records off the contig or beyond the window
         while (kept_before > 0) begin
            o = ring[oldest];
            span = {32'd0, cur.pos} - {32'd0, o.pos};
            if (o.contig == cur.contig && span <= {32'd0, window}) break;
            oldest = (oldest + 1) % STORE_DEPTH;
            kept_before--;
            stored--;
         end
         // admit later records until the first one that fails
         while (admitted + 1 < waiting) begin
            o = ring[(cur_idx + admitted + 1) % STORE_DEPTH];
            span = {32'd0, o.pos} - {32'd0, cur.pos};
            if (o.contig != cur.contig || span > {32'd0, window}) break;
            admitted++;
         end
         queue_window();
      endfunction

      function void note_input(req_type q);
         case (q.func)
            FUNC_PUSH: begin
               if (stored >= STORE_DEPTH) queue_status(ST_FULL);
               else begin
                  ring[wr_idx].contig = q.contig_id;
                  ring[wr_idx].pos    = q.position;
                  ring[wr_idx].len    = q.ref_length;
                  wr_idx = (wr_idx + 1) % STORE_DEPTH;
                  stored++;
                  queue_status(ST_OK);
               end
            end
            FUNC_NEXT:  advance();
            FUNC_CLEAR: begin
               reset_state();
               queue_status(ST_OK);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word %h", $realtime, got);
            errors++;
            return;
         end
         want = pending_words[0];
         pending_words.delete(0);
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
            errors++;
         end
         if (got.role !== want.role) begin
            $display("%0t: role expected %0d actual %0d", $realtime, want.role, got.role);
            errors++;
         end
         if (got.out_contig !== want.out_contig) begin
            $display("%0t: contig expected %h actual %h", $realtime,
                     want.out_contig, got.out_contig);
            errors++;
         end
         if (got.out_position !== want.out_position) begin
            $display("%0t: position expected %h actual %h", $realtime,
                     want.out_position, got.out_position);
            errors++;
         end
         if (got.out_ref_length !== want.out_ref_length) begin
            $display("%0t: ref length expected %h actual %h", $realtime,
                     want.out_ref_length, got.out_ref_length);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $realtime, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_stall;
   req_type     req_data;
   logic        rsp_valid, rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   window_scoreboard sb;
   int          hold_cycles;      // long receiver hold requested by the sender
   logic [15:0] cur_contig;
   logic [31:0] cur_pos;

   windowed_variant_neighbour_buffer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous limit: a few hundred items, each a full walk plus stalled words
   initial begin
      #20ms;
      $display("tb_windowed_variant_neighbour_buffer: errors");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: check each accepted word, then pick the next stall
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_cycles > 0) begin
            // hold off long enough for the block to back up its input
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = gap_length();
            rsp_stall <= (stall_left > 0);
         end
      end
   end

   // Offer one word, hold it until taken, then idle for a random gap
   task automatic send_word(req_type q, bit no_gap = 0);
      int g;
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(q);
      g = no_gap ? 0 : gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic push(logic [15:0] c, logic [31:0] p, logic [15:0] l, bit no_gap = 0);
      req_type q;
      q.func = FUNC_PUSH; q.contig_id = c; q.position = p; q.ref_length = l;
      send_word(q, no_gap);
   endtask

   task automatic command(logic [1:0] f);
      req_type q;
      q = '0;
      q.func = f;
      send_word(q);
   endtask

   // Pause until every expected word has come, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (4 * STORE_DEPTH + 20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_WINDOW_SIZE) sb.window = val;
      else if (idx == CSR_NONOVERLAP) sb.nonoverlap = val[0];
   endtask

   task automatic configure(logic [31:0] win, bit nonov);
      write_csr(CSR_WINDOW_SIZE, win);
      write_csr(CSR_NONOVERLAP, {31'd0, nonov});
      csr_valid <= 1'b0;
   endtask

   // Mostly sorted records with random steps, some noise and broken sequences
   task automatic random_items(int n);
      int      r;
      req_type q;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            if ($urandom_range(0, 19) == 0) cur_contig = 16'($urandom);
            if ($urandom_range(0, 3) == 0) cur_pos = cur_pos + $urandom;
            else cur_pos = cur_pos + $urandom_range(0, 300);
            push(cur_contig, cur_pos,
                 ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(1, 400)));
         end else if (r < 88) command(FUNC_NEXT);
         else if (r < 92) begin
            command(FUNC_CLEAR);
            cur_pos = $urandom_range(0, 2000);
         end else if (r < 95) begin
            q = {FUNC_UNUSED, 16'($urandom), 32'($urandom), 16'($urandom)};
            send_word(q);
         end else begin
            push(16'($urandom), 32'($urandom), 16'($urandom_range(1, 65535)));
         end
      end
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      sb.window = '0;
      sb.nonoverlap = 0;
      sb.errors = 0;
      hold_cycles = 0;
      cur_contig = 16'd7;
      cur_pos = 32'd100;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: no current, extremes, position zero under both modes
      configure(32'd1000, 1'b1);
      command(FUNC_NEXT);
      push(16'd5, 32'd0, 16'd1);
      push(16'd5, 32'd10, 16'd5);
      push(16'd5, 32'd12, 16'd3);
      push(16'd5, 32'd20, 16'd65535);
      push(16'd5, 32'd900, 16'd2);
      push(16'hFFFF, 32'hFFFFFFFF, 16'hFFFF);
      repeat (7) command(FUNC_NEXT);
      begin
         req_type q;
         q = {FUNC_UNUSED, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF};
         send_word(q);
      end
      command(FUNC_CLEAR);
      drain();

      configure(32'hFFFFFFFF, 1'b0);
      push(16'd1, 32'd0, 16'd4);
      push(16'd1, 32'hFFFFFFFF, 16'd1);
      push(16'd2, 32'd3, 16'd1);
      repeat (4) command(FUNC_NEXT);
      drain();

      // Random phases across several settings
      configure(32'd0, 1'b0);
      random_items(20);
      drain();
      configure(32'hFFFFFFFF, 1'b1);
      random_items(25);
      drain();
      configure(32'd500, 1'b0);
      random_items(25);
      drain();

      // Pressure: hold the receiver while filling the ring past full
      command(FUNC_CLEAR);
      drain();
      configure(32'd2000, 1'b1);
      hold_cycles = 400;
      for (int i = 0; i < STORE_DEPTH + 3; i++)
         push(16'd9, 32'(i * 40), 16'($urandom_range(1, 60)), 1'b1);
      repeat (3) command(FUNC_NEXT);
      drain();

      configure(32'd300, 1'b1);
      random_items(30);

      drain();
      if (sb.errors == 0 && sb.pending_words.size() == 0)
         $display("tb_windowed_variant_neighbour_buffer: clean");
      else
         $display("tb_windowed_variant_neighbour_buffer: errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/wvnb_pkg.sv
rtl/windowed_variant_neighbour_buffer.sv
rtl/wvnb_checker.sv
tb/tb_windowed_variant_neighbour_buffer.sv
